[rtl/tactile_baseline_calibration_defines.svh]
// Assertion macros shared by the tactile baseline calibration RTL.
`ifndef TACTILE_BASELINE_CALIBRATION_DEFINES_SVH
`define TACTILE_BASELINE_CALIBRATION_DEFINES_SVH

// Checked only out of reset.
`define TBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/tbc_pkg.sv]
// Package of types and constants for the tactile baseline calibration block.
package tbc_pkg;

  localparam int CELLS_DEF = 24;
  localparam int CELL_W    = 5;
  localparam int RAW_W     = 12;
  localparam int SUM_W     = 20;
  localparam int CAL_W     = 8;
  localparam int DVD_W     = SUM_W + 1;
  localparam int DCNT_W    = $clog2(DVD_W);
  localparam int TDATA_W   = 24;

  localparam logic [CAL_W-1:0] CAL_RESET = CAL_W'(40);

  // tdata layout, both directions: cell in the low bits, then the sample
  localparam int CELL_LSB = 0;
  localparam int RAW_LSB  = CELL_LSB + CELL_W;

  // tuser on the slave side
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_START  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic latch_in;
    logic decode;
    logic upd;
    logic div_start;
    logic div_take;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic oob;
    logic open;
    logic open_q;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/tactile_baseline_calibration.sv]
// Tactile baseline calibration: per-cell offset learning and subtraction over a
// stream of cell samples. A start word (tuser high) opens a window of cal_frames
// frames, counted by tlast; window samples are summed per cell and reported with
// pressure zero and the calibrating flag set. Afterwards each sample reports
// raw minus ceil(sum / cal_frames), clamped at zero. Cells at or above CELLS
// give no output. One word is in flight at a time: a start word or an
// out-of-range cell stops at decode, a window sample passes update and finish,
// a later sample divider start, divider wait and finish, as the serial divider
// makes one quotient bit a cycle over the 21-bit dividend. The result sits in
// an output register, so the next word is taken while it waits. The sum memory
// needs no clearing pass; per-cell valid bits give zero sums after reset.
module tactile_baseline_calibration #(
  parameter int CELLS = tbc_pkg::CELLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tbc_pkg::CAL_W-1:0]   cfg_wdata_i,    // cal_frames
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tbc_pkg::TDATA_W-1:0] s_axis_tdata,   // cell_index[4:0], raw_sample[16:5]
  input  logic [0:0]                  s_axis_tuser,   // kind
  input  logic                        s_axis_tlast,   // frame_end
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tbc_pkg::TDATA_W-1:0] m_axis_tdata,   // cell_out[4:0], pressure[16:5]
  output logic [0:0]                  m_axis_tuser    // calibrating
);
  import tbc_pkg::*;
  `include "tactile_baseline_calibration_defines.svh"

  cmd_t cmd;
  sts_t sts;

  tbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbc_dpath #(
    .CELLS (CELLS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser[0]),
    .in_last_i   (s_axis_tlast),
    .out_data_o  (m_axis_tdata),
    .out_cal_o   (m_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  // a pending word is never overwritten
  `TBC_ASSERT(a_no_overwrite, cmd.load_out |-> sts.out_free, "result loaded over a pending word")
  // the divider only serves samples after the window
  `TBC_ASSERT(a_div_closed, cmd.div_start |-> !sts.open_q, "divider started inside the window")
  // calibrating words carry zero pressure
  `TBC_ASSERT(a_cal_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[RAW_LSB +: RAW_W] == '0), "nonzero pressure while calibrating")
  // no input word is taken while the sequencer is busy
  `TBC_ASSERT_ALWAYS(a_ready_idle, (cmd.decode || cmd.upd || cmd.div_start) |-> !s_axis_tready, "input ready while busy")

endmodule

[rtl/tbc_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module tbc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tbc_pkg::DVD_W-1:0]  dividend_i,
  input  logic [tbc_pkg::CAL_W-1:0]  divisor_i,
  output logic [tbc_pkg::DVD_W-1:0]  quotient_o,
  output logic                       done_o
);
  import tbc_pkg::*;

  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [CAL_W:0]    rem_q, rem_d;
  logic [CAL_W-1:0]  dsr_q, dsr_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CAL_W:0]    rem_sh;
  logic              ge;

  // remainder stays below the divisor, so its low bits carry it all
  assign rem_sh = {rem_q[CAL_W-1:0], dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = DCNT_W'(DVD_W - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

[rtl/tbc_dpath.sv]
// Datapath: input word, per-cell sum memory, frame counter, divider, output register.
module tbc_dpath #(
  parameter int CELLS = tbc_pkg::CELLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tbc_pkg::cmd_t               cmd_i,
  output tbc_pkg::sts_t               sts_o,
  input  logic                        cfg_we_i,
  input  logic [tbc_pkg::CAL_W-1:0]   cfg_wdata_i,
  input  logic [tbc_pkg::TDATA_W-1:0] in_data_i,
  input  logic                        in_kind_i,
  input  logic                        in_last_i,
  output logic [tbc_pkg::TDATA_W-1:0] out_data_o,
  output logic                        out_cal_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i
);
  import tbc_pkg::*;

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  // input word
  logic              kind_q;
  logic [CELL_W-1:0] cell_q;
  logic [RAW_W-1:0]  raw_q;
  logic              fend_q;

  logic [CAL_W-1:0]  cal_q;
  logic [CAL_W-1:0]  frames_q, frames_d;
  logic              open_q;
  logic              open_now;
  logic              oob;
  logic [AW-1:0]     addr;

  // sum memory; valid bits stand in for the reset clear
  logic [SUM_W-1:0]  mem [CELLS];
  logic [CELLS-1:0]  vld_q;
  logic [SUM_W-1:0]  rd_q;
  logic              rd_vld_q;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  wdata;

  logic [CAL_W-1:0]  divisor;
  logic [DVD_W-1:0]  dividend;
  logic [DVD_W-1:0]  quot;
  logic              div_done;
  logic [DVD_W-1:0]  raw_ext;

  logic [RAW_W-1:0]  press_q;
  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [RAW_W-1:0]  out_press_q;
  logic              out_cal_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= in_kind_i;
      cell_q <= in_data_i[CELL_LSB +: CELL_W];
      raw_q  <= in_data_i[RAW_LSB +: RAW_W];
      fend_q <= in_last_i;
    end
  end

  assign addr     = AW'(cell_q);
  assign oob      = 32'(cell_q) >= CELLS;
  assign open_now = frames_q < cal_q;

  always_comb begin
    frames_d = frames_q;
    if (cmd_i.decode) begin
      if (kind_q == KIND_START) begin
        frames_d = '0;
      end else if (oob && open_now && fend_q) begin
        frames_d = frames_q + 1'b1;
      end
    end else if (cmd_i.upd && fend_q) begin
      frames_d = frames_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q    <= CAL_RESET;
      frames_q <= CAL_RESET;
    end else begin
      if (cfg_we_i) begin
        cal_q <= cfg_wdata_i;
      end
      frames_q <= frames_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      open_q <= open_now;
    end
  end

  assign sum     = rd_vld_q ? rd_q : '0;
  assign sum_add = {1'b0, sum} + (SUM_W + 1)'(raw_q);
  // first frame of the window overwrites the old sum
  assign wdata   = (frames_q == '0) ? SUM_W'(raw_q)
                 : (sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.decode) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        vld_q[addr] <= 1'b1;
      end
      if (cmd_i.decode) begin
        rd_vld_q <= vld_q[addr];
      end
    end
  end

  // ceil(sum / div) as floor((sum + div - 1) / div)
  assign divisor  = (cal_q == '0) ? CAL_W'(1) : cal_q;
  assign dividend = {1'b0, sum} + DVD_W'(divisor) - DVD_W'(1);

  tbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  assign raw_ext = DVD_W'(raw_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      press_q <= '0;
    end else if (cmd_i.div_take) begin
      press_q <= (raw_ext > quot) ? RAW_W'(raw_ext - quot) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cell_q  <= cell_q;
      out_press_q <= press_q;
      out_cal_q   <= open_q;
    end
  end

  assign out_data_o  = TDATA_W'({out_press_q, out_cell_q});
  assign out_cal_o   = out_cal_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o          = '0;
    sts_o.is_start = (kind_q == KIND_START);
    sts_o.oob      = oob;
    sts_o.open     = open_now;
    sts_o.open_q   = open_q;
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

[rtl/tbc_ctrl.sv]
// Controller state machine sequencing each input word through the datapath.
module tbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tbc_pkg::sts_t sts_i,
  output tbc_pkg::cmd_t cmd_o
);
  import tbc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts_i.is_start || sts_i.oob) begin
          state_d = ST_IDLE;
        end else if (sts_i.open) begin
          state_d = ST_UPDATE;
        end else begin
          state_d = ST_DIV_START;
        end
      end
      ST_UPDATE:    state_d = ST_FINISH;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts_i.div_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_DECODE:    cmd_o.decode    = 1'b1;
      ST_UPDATE:    cmd_o.upd       = 1'b1;
      ST_DIV_START: cmd_o.div_start = 1'b1;
      ST_DIV_WAIT:  cmd_o.div_take  = sts_i.div_done;
      ST_FINISH:    cmd_o.load_out  = sts_i.out_free;
      default:      cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[tb/tactile_baseline_calibration_tb.sv]
// Self-checking bench for the tactile baseline calibration block.
module tactile_baseline_calibration_tb;
  import tbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WORD_TARGET    = 750;

  typedef struct packed {
    logic [CELL_W-1:0] cell_id;
    logic [RAW_W-1:0]  pressure;
    logic              calibrating;
  } pressure_word_t;

  // Baseline predictor plus the queue of pressure words still owed by the block
  class calib_scoreboard;
    logic [CAL_W-1:0] cal_frames_q;
    logic [CAL_W-1:0] frames_seen_q;
    logic [SUM_W-1:0] cell_sum[CELLS_DEF];
    pressure_word_t   pressure_q[$];
    int               errors;

    function new();
      cal_frames_q  = CAL_RESET;
      frames_seen_q = CAL_RESET;
      foreach (cell_sum[c]) cell_sum[c] = '0;
      errors = 0;
    endfunction

    function void write_cal(input logic [CAL_W-1:0] value);
      cal_frames_q = value;
    endfunction

    function void note_word(input logic kind, input logic [CELL_W-1:0] cell_id,
                            input logic [RAW_W-1:0] raw, input logic fend);
      logic           open;
      int unsigned    divisor;
      int unsigned    base;
      int unsigned    total;
      pressure_word_t w;
      if (kind == KIND_START) begin
        frames_seen_q = '0;
        return;
      end
      open = frames_seen_q < cal_frames_q;
      // out-of-range cells still close a frame but leave no trace otherwise
      if (cell_id >= CELLS_DEF) begin
        if (open && fend) frames_seen_q = frames_seen_q + 1'b1;
        return;
      end
      w.cell_id     = cell_id;
      w.calibrating = open;
      w.pressure    = '0;
      if (open) begin
        if (frames_seen_q == '0) begin
          cell_sum[cell_id] = SUM_W'(raw);
        end else begin
          total = int'(cell_sum[cell_id]) + int'(raw);
          cell_sum[cell_id] = (total > (2**SUM_W - 1)) ? {SUM_W{1'b1}} : SUM_W'(total);
        end
        if (fend) frames_seen_q = frames_seen_q + 1'b1;
      end else begin
        divisor = (cal_frames_q == '0) ? 1 : int'(cal_frames_q);
        base    = (int'(cell_sum[cell_id]) + divisor - 1) / divisor;
        w.pressure = (raw > base) ? RAW_W'(raw - base) : '0;
      end
      pressure_q.push_back(w);
    endfunction

    function void check_word(input logic [CELL_W-1:0] cell_id,
                             input logic [RAW_W-1:0] pressure,
                             input logic calibrating);
      pressure_word_t w;
      if (pressure_q.size() == 0) begin
        $error("unexpected word: cell_out %0d pressure %0d calibrating %0b",
               cell_id, pressure, calibrating);
        errors++;
        return;
      end
      w = pressure_q.pop_front();
      if (cell_id !== w.cell_id) begin
        $error("cell_out: expected %0d, got %0d", w.cell_id, cell_id);
        errors++;
      end
      if (pressure !== w.pressure) begin
        $error("pressure: expected %0d, got %0d", w.pressure, pressure);
        errors++;
      end
      if (calibrating !== w.calibrating) begin
        $error("calibrating: expected %0b, got %0b", w.calibrating, calibrating);
        errors++;
      end
    endfunction

    function int pending();
      return pressure_q.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CAL_W-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [0:0]          m_axis_tuser;

  calib_scoreboard sb = new();
  int burst_left  = 0;
  int words_sent  = 0;
  int ready_hold  = 0;
  int idle_cycles = 0;

  tactile_baseline_calibration dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // receiver: ready runs and stalls of random length
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(1, 12);
      end else begin
        m_axis_tready <= 1'b1;
        ready_hold    <= $urandom_range(1, 40);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata[CELL_LSB +: CELL_W], m_axis_tdata[RAW_LSB +: RAW_W],
                    m_axis_tuser[0]);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(input logic kind, input logic [CELL_W-1:0] cell_id,
                           input logic [RAW_W-1:0] raw, input logic fend);
    logic [TDATA_W-1:0] packed_word;
    packed_word = '0;
    packed_word[CELL_LSB +: CELL_W] = cell_id;
    packed_word[RAW_LSB +: RAW_W]   = raw;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= packed_word;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= fend;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(kind, cell_id, raw, fend);
    words_sent++;
  endtask

  // drain, let any word with no result finish, then write cal_frames
  task automatic write_cal_frames(input logic [CAL_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_cal(value);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CELL_W-1:0] pick_cell();
    if ($urandom_range(0, 7) == 0) return CELL_W'($urandom_range(CELLS_DEF, 31));
    return CELL_W'($urandom_range(0, CELLS_DEF - 1));
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {RAW_W{1'b1}};
      2, 3:    return RAW_W'($urandom_range(0, 63));
      default: return RAW_W'($urandom());
    endcase
  endfunction

  // one calibration window (or a reopened one) followed by plain frames
  task automatic run_window(input logic [CAL_W-1:0] cal, input bit with_start, input int frames,
                            input int max_len, input bit noisy);
    int len;
    write_cal_frames(cal);
    if (with_start)
      send_word(KIND_START, CELL_W'($urandom()), RAW_W'($urandom()), 1'($urandom()));
    for (int f = 0; f < frames; f++) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
        if (noisy && $urandom_range(0, 39) == 0)
          send_word(KIND_START, CELL_W'($urandom()), RAW_W'($urandom()), 1'($urandom()));
        send_word(KIND_SAMPLE, pick_cell(), pick_raw(), i == len - 1);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the window is shut and every sum is zero
    send_word(KIND_SAMPLE, 5'd0, 12'hFFF, 1'b0);
    send_word(KIND_SAMPLE, 5'd23, 12'h000, 1'b1);
    send_word(KIND_SAMPLE, 5'd31, 12'hFFF, 1'b1);
    send_word(KIND_SAMPLE, 5'd24, 12'd123, 1'b0);

    // one-frame window: every first-frame word overwrites, out-of-range cell ends the frame
    write_cal_frames(8'd1);
    send_word(KIND_START, 5'd31, 12'hFFF, 1'b1);
    send_word(KIND_SAMPLE, 5'd5, 12'd100, 1'b0);
    send_word(KIND_SAMPLE, 5'd5, 12'd200, 1'b0);
    send_word(KIND_SAMPLE, 5'd30, 12'd77, 1'b1);
    send_word(KIND_SAMPLE, 5'd5, 12'd150, 1'b0);
    send_word(KIND_SAMPLE, 5'd5, 12'hFFF, 1'b0);
    send_word(KIND_SAMPLE, 5'd7, 12'd10, 1'b1);

    // raising the count reopens the window and adds to the old sums
    write_cal_frames(8'd3);
    send_word(KIND_SAMPLE, 5'd5, 12'd7, 1'b1);
    send_word(KIND_SAMPLE, 5'd9, 12'd300, 1'b0);
    send_word(KIND_SAMPLE, 5'd5, 12'd9, 1'b1);
    send_word(KIND_SAMPLE, 5'd5, 12'd100, 1'b0);
    send_word(KIND_SAMPLE, 5'd9, 12'd4000, 1'b1);
    // lowering it after a fresh start shuts the window at once
    send_word(KIND_START, 5'd0, 12'd0, 1'b0);
    send_word(KIND_SAMPLE, 5'd5, 12'd50, 1'b1);
    write_cal_frames(8'd1);
    send_word(KIND_SAMPLE, 5'd5, 12'd60, 1'b1);

    // saturating sum: second frame piles full-scale samples onto one cell
    write_cal_frames(8'd2);
    send_word(KIND_START, 5'd0, 12'd0, 1'b0);
    send_word(KIND_SAMPLE, 5'd0, 12'd1, 1'b1);
    for (int i = 0; i < 258; i++)
      send_word(KIND_SAMPLE, 5'd0, 12'hFFF, i == 257);
    send_word(KIND_SAMPLE, 5'd0, 12'hFFF, 1'b0);
    send_word(KIND_SAMPLE, 5'd0, 12'd1, 1'b1);

    // longest window, one word per frame, then a few words past it
    run_window(8'd255, 1'b1, 260, 1, 1'b0);

    while (words_sent < WORD_TARGET) begin
      run_window(($urandom_range(0, 5) == 0) ? 8'd1 : CAL_W'($urandom_range(1, 6)),
                 $urandom_range(0, 3) != 0, $urandom_range(1, 10), $urandom_range(1, 8), 1'b1);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
